[rtl/coverage_navigation_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// coverage navigation sequencer assertion macros
// clocked concurrent checks on clock, optionally gated by reset
// ----------------------------------------------------------------------------
`ifndef COVERAGE_NAVIGATION_SEQUENCER_CORE_DEFINES_SVH
`define COVERAGE_NAVIGATION_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check that is switched off while reset is high
`define CNS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also holds across reset
`define CNS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CNS_ASSERT(lbl, prop, msg)
`define CNS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/cns_pkg.sv]
// ----------------------------------------------------------------------------
// cns_pkg
// shared widths, phase codes, register indexes and stage types
// ----------------------------------------------------------------------------
`default_nettype none

package cns_pkg;

   localparam int THR_W       = 12;
   localparam int YAW_W       = 16;
   localparam int MS_W        = 10;
   localparam int WHEEL_W     = 24;
   localparam int SPEED_W     = 11;
   localparam int CFG_SPEED_W = 10;
   localparam int STEP_W      = 16;
   localparam int TARGET_W    = 22;
   localparam int ANGLE_W     = 32;
   localparam int PROD_W      = YAW_W + MS_W + 1;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 22;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FRONT_THR   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIDE_THR    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FWD_SPEED   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPIN_SPEED  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHORT_LEN   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TURN_TARGET = 3'd5;

   // register reset values
   localparam int FRONT_THR_RST   = 300;
   localparam int SIDE_THR_RST    = 450;
   localparam int FWD_SPEED_RST   = 800;
   localparam int SPIN_SPEED_RST  = 500;
   localparam int SHORT_LEN_RST   = 100;
   localparam int TURN_TARGET_RST = 1570796;

   typedef enum logic [2:0] {
      PH_START      = 3'd0,
      PH_LONG       = 3'd1,
      PH_TURN_SHORT = 3'd2,
      PH_SHORT      = 3'd3,
      PH_TURN_LONG  = 3'd4
   } phase_type;

   // per-tick facts prepared in the input stage
   typedef struct packed {
      logic                     obstacle;
      logic                     step_done;
      logic signed [PROD_W-1:0] product;
   } front_type;

   // one result
   typedef struct packed {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic                      clear_position;
      phase_type                 phase;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/cns_front.sv]
// ----------------------------------------------------------------------------
// cns_front
// input stage: obstacle and step compares, yaw times elapsed product
// ----------------------------------------------------------------------------
`default_nettype none

module cns_front import cns_pkg::*; #(
   parameter int PROX_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic [PROX_BITS-1:0]        prox_front_right,
   input  wire logic [PROX_BITS-1:0]        prox_front_left,
   input  wire logic [PROX_BITS-1:0]        prox_diag_right,
   input  wire logic [PROX_BITS-1:0]        prox_diag_left,
   input  wire logic signed [YAW_W-1:0]     yaw_rate,
   input  wire logic [MS_W-1:0]             elapsed_ms,
   input  wire logic signed [WHEEL_W-1:0]   wheel_position,
   input  wire logic [PROX_BITS-1:0]        front_threshold,
   input  wire logic [PROX_BITS-1:0]        side_threshold,
   input  wire logic [STEP_W-1:0]           short_step_length,
   output front_type                        front
);

   front_type front_ff;
   front_type front_in;

   always_comb begin
      front_in.obstacle = (prox_front_right > front_threshold) ||
                          (prox_front_left  > front_threshold) ||
                          (prox_diag_right  > side_threshold)  ||
                          (prox_diag_left   > side_threshold);
      // signed wheel count against unsigned step length
      front_in.step_done = $signed({wheel_position[WHEEL_W-1], wheel_position}) >=
                           $signed({{(WHEEL_W + 1 - STEP_W){1'b0}}, short_step_length});
      front_in.product = PROD_W'(yaw_rate * $signed({1'b0, elapsed_ms}));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

`default_nettype wire

[rtl/cns_seq.sv]
// ----------------------------------------------------------------------------
// cns_seq
// five-phase sweep sequencer with angle integration and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cns_seq import cns_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire front_type               front,
   input  wire logic [CFG_SPEED_W-1:0]  fwd_speed,
   input  wire logic [CFG_SPEED_W-1:0]  spin_speed,
   input  wire logic [TARGET_W-1:0]     turn_target,
   output rsp_type                      rsp
);

   localparam int SUM_W = ANGLE_W + 1;

   phase_type                  phase_ff, phase_in;
   logic [1:0]                 turn_ff, turn_in;
   logic [1:0]                 inc_ff, inc_in;
   logic signed [ANGLE_W-1:0]  angle_ff, angle_in;
   logic signed [SPEED_W-1:0]  left_ff, left_in;
   logic signed [SPEED_W-1:0]  right_ff, right_in;
   logic                       clear_ff, clear_in;

   logic [SUM_W-1:0]           sum;
   logic [ANGLE_W-1:0]         angle_sat;
   logic [ANGLE_W-1:0]         angle_mag;
   logic                       turn_done;
   logic                       begin_turn;
   logic                       go_fwd;
   logic signed [SPEED_W-1:0]  turn_spd;

   // saturating angle update and magnitude test
   always_comb begin
      sum = {angle_ff[ANGLE_W-1], angle_ff} +
            {{(SUM_W - PROD_W){front.product[PROD_W-1]}}, front.product};
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         angle_sat = sum[SUM_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
      end else begin
         angle_sat = sum[ANGLE_W-1:0];
      end
      angle_mag = angle_sat[ANGLE_W-1] ? (~angle_sat + ANGLE_W'(1)) : angle_sat;
      turn_done = angle_mag >= {{(ANGLE_W - TARGET_W){1'b0}}, turn_target};
      turn_spd  = $signed({1'b0, spin_speed});
   end

   always_comb begin
      phase_in   = phase_ff;
      turn_in    = turn_ff;
      inc_in     = inc_ff;
      angle_in   = angle_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      clear_in   = 1'b0;
      begin_turn = 1'b0;
      go_fwd     = 1'b0;
      case (phase_ff)
         PH_LONG: begin
            if (front.obstacle) begin
               begin_turn = 1'b1;
               phase_in   = PH_TURN_SHORT;
            end
         end
         PH_TURN_SHORT: begin
            angle_in = angle_sat;
            if (turn_done) begin
               clear_in = 1'b1;
               go_fwd   = 1'b1;
               turn_in  = turn_ff + 2'd1;
               phase_in = PH_SHORT;
            end
         end
         PH_SHORT: begin
            if (front.obstacle) begin
               // saturates at three
               if (inc_ff != 2'd3) begin
                  inc_in = inc_ff + 2'd1;
               end
               begin_turn = 1'b1;
               phase_in   = PH_TURN_LONG;
            end else if (front.step_done) begin
               inc_in     = 2'd0;
               begin_turn = 1'b1;
               phase_in   = PH_TURN_LONG;
            end
         end
         PH_TURN_LONG: begin
            angle_in = angle_sat;
            if (turn_done) begin
               go_fwd = 1'b1;
               // two short steps cut short in a row reverse the sweep
               if (inc_ff > 2'd1) begin
                  turn_in = turn_ff + 2'd3;
                  inc_in  = 2'd0;
               end else begin
                  turn_in = turn_ff + 2'd1;
               end
               phase_in = PH_LONG;
            end
         end
         default: begin
            go_fwd   = 1'b1;
            phase_in = PH_LONG;
         end
      endcase
      if (go_fwd) begin
         left_in  = $signed({1'b0, fwd_speed});
         right_in = $signed({1'b0, fwd_speed});
      end
      if (begin_turn) begin
         angle_in = '0;
         if (!turn_ff[1]) begin
            left_in  = turn_spd;
            right_in = -turn_spd;
         end else begin
            left_in  = -turn_spd;
            right_in = turn_spd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         turn_ff  <= 2'd0;
         inc_ff   <= 2'd0;
         angle_ff <= '0;
         left_ff  <= '0;
         right_ff <= '0;
         clear_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         turn_ff  <= turn_in;
         inc_ff   <= inc_in;
         angle_ff <= angle_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         clear_ff <= clear_in;
      end
   end

   assign rsp.left_speed     = left_ff;
   assign rsp.right_speed    = right_ff;
   assign rsp.clear_position = clear_ff;
   assign rsp.phase          = phase_ff;

endmodule

`default_nettype wire

[rtl/coverage_navigation_sequencer_core.sv]
// ----------------------------------------------------------------------------
// coverage_navigation_sequencer_core
// boustrophedon sweep sequencer: one wheel command result per control tick
// ----------------------------------------------------------------------------
//
// channel  direction  handshake          payload
// req      in         req_valid/stall    four prox readings, yaw, ms, wheel
// rsp      out        rsp_valid/stall    left/right speed, clear, phase
// csr      in         csr_valid/ready    register index and write data
//
// one transfer per cycle sustained while rsp_stall stays low; a tick passes
// the input register, then the result register, before it shows on rsp
// the product yaw times ms sits in the input register, the angle add,
// saturate and magnitude compare sit in front of the result register
// synchronous reset restores register defaults and the start phase
// req_stall rises only while the input register is full and the result
// register is held by rsp_stall
// csr writes are always ready; they are expected only while no tick is open
// ----------------------------------------------------------------------------
`default_nettype none

`include "coverage_navigation_sequencer_core_defines.svh"

module coverage_navigation_sequencer_core import cns_pkg::*; #(
   parameter int PROX_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [PROX_BITS-1:0]        req_prox_front_right,
   input  wire logic [PROX_BITS-1:0]        req_prox_front_left,
   input  wire logic [PROX_BITS-1:0]        req_prox_diag_right,
   input  wire logic [PROX_BITS-1:0]        req_prox_diag_left,
   input  wire logic signed [YAW_W-1:0]     req_yaw_rate,
   input  wire logic [MS_W-1:0]             req_elapsed_ms,
   input  wire logic signed [WHEEL_W-1:0]   req_wheel_position,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [SPEED_W-1:0]        rsp_left_speed,
   output logic signed [SPEED_W-1:0]        rsp_right_speed,
   output logic                             rsp_clear_position,
   output logic [2:0]                       rsp_phase,

   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_ADDR_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers; thresholds keep their full width and are
   // taken at PROX_BITS bits where they are compared
   logic [THR_W-1:0]        front_thr_ff, front_thr_in;
   logic [THR_W-1:0]        side_thr_ff, side_thr_in;
   logic [CFG_SPEED_W-1:0]  fwd_speed_ff, fwd_speed_in;
   logic [CFG_SPEED_W-1:0]  spin_speed_ff, spin_speed_in;
   logic [STEP_W-1:0]       short_len_ff, short_len_in;
   logic [TARGET_W-1:0]     turn_target_ff, turn_target_in;

   // handshake control
   logic                    s1_valid_ff, s1_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    advance;
   logic                    load_s1;
   logic                    csr_write;

   front_type               front;
   rsp_type                 rsp;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // register write decode; unknown indexes are dropped
   always_comb begin
      front_thr_in   = front_thr_ff;
      side_thr_in    = side_thr_ff;
      fwd_speed_in   = fwd_speed_ff;
      spin_speed_in  = spin_speed_ff;
      short_len_in   = short_len_ff;
      turn_target_in = turn_target_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRONT_THR:   front_thr_in   = csr_wdata[THR_W-1:0];
            CSR_SIDE_THR:    side_thr_in    = csr_wdata[THR_W-1:0];
            CSR_FWD_SPEED:   fwd_speed_in   = csr_wdata[CFG_SPEED_W-1:0];
            CSR_SPIN_SPEED:  spin_speed_in  = csr_wdata[CFG_SPEED_W-1:0];
            CSR_SHORT_LEN:   short_len_in   = csr_wdata[STEP_W-1:0];
            CSR_TURN_TARGET: turn_target_in = csr_wdata[TARGET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_thr_ff   <= THR_W'(FRONT_THR_RST);
         side_thr_ff    <= THR_W'(SIDE_THR_RST);
         fwd_speed_ff   <= CFG_SPEED_W'(FWD_SPEED_RST);
         spin_speed_ff  <= CFG_SPEED_W'(SPIN_SPEED_RST);
         short_len_ff   <= STEP_W'(SHORT_LEN_RST);
         turn_target_ff <= TARGET_W'(TURN_TARGET_RST);
      end else begin
         front_thr_ff   <= front_thr_in;
         side_thr_ff    <= side_thr_in;
         fwd_speed_ff   <= fwd_speed_in;
         spin_speed_ff  <= spin_speed_in;
         short_len_ff   <= short_len_in;
         turn_target_ff <= turn_target_in;
      end
   end

   // the input register moves on whenever the result register is empty
   // or being drained this cycle
   assign advance      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign load_s1      = req_valid && !req_stall;
   assign s1_valid_in  = load_s1 || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   cns_front #(
      .PROX_BITS (PROX_BITS)
   ) u_front (
      .clock             (clock),
      .load              (load_s1),
      .prox_front_right  (req_prox_front_right),
      .prox_front_left   (req_prox_front_left),
      .prox_diag_right   (req_prox_diag_right),
      .prox_diag_left    (req_prox_diag_left),
      .yaw_rate          (req_yaw_rate),
      .elapsed_ms        (req_elapsed_ms),
      .wheel_position    (req_wheel_position),
      .front_threshold   (PROX_BITS'(front_thr_ff)),
      .side_threshold    (PROX_BITS'(side_thr_ff)),
      .short_step_length (short_len_ff),
      .front             (front)
   );

   // sequencer state doubles as the result register
   cns_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .front       (front),
      .fwd_speed   (fwd_speed_ff),
      .spin_speed  (spin_speed_ff),
      .turn_target (turn_target_ff),
      .rsp         (rsp)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_left_speed     = rsp.left_speed;
   assign rsp_right_speed    = rsp.right_speed;
   assign rsp_clear_position = rsp.clear_position;
   assign rsp_phase          = rsp.phase;

   // reset empties both stages
   `CNS_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && !s1_valid_ff), "stages not empty after reset")
   // a tick leaving the input register lands in the result register
   `CNS_ASSERT(a_advance_lands, advance |=> rsp_valid, "advanced tick lost")
   // clear request only on entry to the short step
   `CNS_ASSERT(a_clear_phase, (rsp_valid && rsp_clear_position) |-> (rsp_phase == PH_SHORT), "clear outside short step")
   // straight phases drive both wheels alike
   `CNS_ASSERT(a_fwd_equal, (rsp_valid && (rsp_phase == PH_LONG || rsp_phase == PH_SHORT)) |-> (rsp_left_speed == rsp_right_speed), "forward phase with unequal wheels")
   // turning phases spin in place
   `CNS_ASSERT(a_turn_opposite, (rsp_valid && (rsp_phase == PH_TURN_SHORT || rsp_phase == PH_TURN_LONG)) |-> (rsp_left_speed == -rsp_right_speed), "turn phase not in place")

endmodule

`default_nettype wire
